// ===== design/ipv4_route_prefix_filter_top_defines.svh =====
// assertion macros for the ipv4 route prefix filter
// used by ipv4_route_prefix_filter_top, no other dependencies
`ifndef IPV4_ROUTE_PREFIX_FILTER_TOP_DEFINES_SVH
`define IPV4_ROUTE_PREFIX_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked on aclk, off while reset is low
`define IPRPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk, off while reset is low
`define IPRPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/iprpf_pkg.sv =====
// shared types, constants and mask helper for the ipv4 route prefix filter
// no dependencies
package iprpf_pkg;

    localparam int ADDR_W   = 32;
    localparam int PFX_W    = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [PFX_W-1:0] MAX_PREFIX = 6'd32;

    // register index, taken from paddr bit 2
    localparam logic REG_MIN_PUBLIC = 1'b0;
    localparam logic REG_MIN_LOCAL  = 1'b1;

    localparam logic [PFX_W-1:0] MIN_PUBLIC_RESET = 6'd16;
    localparam logic [PFX_W-1:0] MIN_LOCAL_RESET  = 6'd24;

    localparam logic [15:0] LINK_LOCAL_HI = 16'ha9fe;

    localparam int RESERVED_COUNT = 14;
    localparam int LOCAL_COUNT    = 4;

    localparam logic [ADDR_W-1:0] RESERVED_BASE [RESERVED_COUNT] = '{
        32'h00000000, 32'h7f000000, 32'hc0000000, 32'hc0000200,
        32'hc01f0000, 32'hc01fc400, 32'hc034c100, 32'hc0586300,
        32'hc0af3000, 32'hc6120000, 32'hc6336400, 32'hcb007100,
        32'he0000000, 32'hf0000000
    };
    localparam logic [PFX_W-1:0] RESERVED_LEN [RESERVED_COUNT] = '{
        6'd8,  6'd8,  6'd24, 6'd24, 6'd24, 6'd24, 6'd24,
        6'd24, 6'd24, 6'd15, 6'd24, 6'd24, 6'd4,  6'd4
    };

    localparam logic [ADDR_W-1:0] LOCAL_BASE [LOCAL_COUNT] = '{
        32'h0a000000, 32'h64400000, 32'hac100000, 32'hc0a80000
    };
    localparam logic [PFX_W-1:0] LOCAL_LEN [LOCAL_COUNT] = '{
        6'd8, 6'd10, 6'd12, 6'd16
    };

    typedef struct packed {
        logic [PFX_W-1:0] min_public;
        logic [PFX_W-1:0] min_local;
    } iprpf_cfg_t;

    // network mask, ones in the top len bits and zeros below
    function automatic logic [ADDR_W-1:0] net_mask(input logic [PFX_W-1:0] len);
        net_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

// ===== design/iprpf_classify.sv =====
// combinational route classifier: reserved, link-local, host bits, minimum prefix
// depends on iprpf_pkg
module iprpf_classify
    import iprpf_pkg::*;
(
    input  logic [ADDR_W-1:0] route_address,
    input  logic [PFX_W-1:0]  prefix_length,
    input  iprpf_cfg_t        cfg,
    output logic              accept
);

    logic [ADDR_W-1:0]         mask;
    logic [RESERVED_COUNT-1:0] hit_reserved;
    logic [LOCAL_COUNT-1:0]    hit_local;
    logic [PFX_W-1:0]          need;
    logic                      len_ok;
    logic                      host_clear;
    logic                      link_local;

    assign mask       = net_mask(prefix_length);
    assign len_ok     = (prefix_length != '0) && (prefix_length <= MAX_PREFIX);
    assign host_clear = ((route_address & mask) == route_address);
    assign link_local = (route_address[ADDR_W-1:ADDR_W-16] == LINK_LOCAL_HI);

    // aligned prefixes overlap when they agree over the shorter mask
    always_comb begin
        for (int i = 0; i < RESERVED_COUNT; i++) begin
            hit_reserved[i] = (((route_address & mask) ^ RESERVED_BASE[i])
                               & mask & net_mask(RESERVED_LEN[i])) == '0;
        end
        for (int j = 0; j < LOCAL_COUNT; j++) begin
            hit_local[j] = ((route_address & net_mask(LOCAL_LEN[j])) == LOCAL_BASE[j]);
        end
    end

    assign need   = (|hit_local) ? cfg.min_local : cfg.min_public;
    assign accept = len_ok && host_clear && !link_local && !(|hit_reserved)
                    && (prefix_length >= need);

endmodule

// ===== design/ipv4_route_prefix_filter_top.sv =====
// top level of the ipv4 route prefix filter: handshake stages and apb registers
// depends on iprpf_pkg, iprpf_classify and ipv4_route_prefix_filter_top_defines.svh
//
// usage
//   input channel: s_valid / s_ready with s_route_address and s_prefix_length;
//   a transfer takes place at a rising edge with both valid and ready high
//   result channel: m_valid / m_ready with m_accept, one result per input transfer
//   path: an input transfer loads the input register, the classifier logic works
//   on it, and the result register then takes the accept flag and raises m_valid
//   throughput: one transfer per cycle while m_ready is high, set by the two-stage register pipeline;
//   the classifier is a parallel bank of mask compares with no loop
//   stall: when m_ready is low the result register holds, the input register
//   still fills, and s_ready drops only while both stages are full
//   reset: aresetn low at a rising edge empties both stages and loads the
//   minimum prefix registers with 16 (public) and 24 (local)
//   config: apb writes at address 0 (min_public_prefix) and 4 (min_local_prefix),
//   only bit 2 of paddr selects; pready is tied high; write while idle
module ipv4_route_prefix_filter_top
    import iprpf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ADDR_W-1:0]  s_route_address,
    input  logic [PFX_W-1:0]   s_prefix_length,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accept,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

`include "ipv4_route_prefix_filter_top_defines.svh"

    // configuration registers
    iprpf_cfg_t cfg_reg;
    iprpf_cfg_t cfg_next;
    logic       cfg_write;

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [PFX_W-1:0]  pfx_reg;

    // result stage
    logic out_valid_reg;
    logic out_valid_next;
    logic accept_reg;
    logic accept_comb;

    logic out_advance;
    logic in_transfer;
    logic out_transfer;

    // ------------------------------------------------------------------
    // apb port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_MIN_PUBLIC: cfg_next.min_public = pwdata[PFX_W-1:0];
                REG_MIN_LOCAL:  cfg_next.min_local  = pwdata[PFX_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_public <= MIN_PUBLIC_RESET;
            cfg_reg.min_local  <= MIN_LOCAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back; misaligned addresses read as zero
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (paddr[2])
                REG_MIN_PUBLIC: prdata = {{(PDATA_W-PFX_W){1'b0}}, cfg_reg.min_public};
                REG_MIN_LOCAL:  prdata = {{(PDATA_W-PFX_W){1'b0}}, cfg_reg.min_local};
                default:        prdata = '0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // two-stage pipeline
    // ------------------------------------------------------------------
    // result stage frees when empty or when its transfer completes
    assign out_advance  = !out_valid_reg || m_ready;
    assign s_ready      = !in_valid_reg || out_advance;
    assign in_transfer  = s_valid && s_ready;
    assign out_transfer = out_valid_reg && m_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_transfer) begin
            in_valid_next = 1'b1;
        end else if (out_advance) begin
            in_valid_next = 1'b0;
        end
    end

    assign out_valid_next = out_advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_transfer) begin
            addr_reg <= s_route_address;
            pfx_reg  <= s_prefix_length;
        end
        if (out_advance) begin
            accept_reg <= accept_comb;
        end
    end

    iprpf_classify u_classify (
        .route_address (addr_reg),
        .prefix_length (pfx_reg),
        .cfg           (cfg_reg),
        .accept        (accept_comb)
    );

    assign m_valid  = out_valid_reg;
    assign m_accept = accept_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `IPRPF_ASSERT_SAME(a_stall_only_when_full, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready, "s_ready low with a free stage")
    `IPRPF_ASSERT_NEXT(a_zero_prefix_rejected,
        in_valid_reg && out_advance && (pfx_reg == '0),
        m_valid && !m_accept, "zero prefix route not rejected")
    `IPRPF_ASSERT_NEXT(a_cfg_public_written,
        cfg_write && (paddr[2] == REG_MIN_PUBLIC),
        cfg_reg.min_public == $past(pwdata[PFX_W-1:0]), "min_public_prefix not written")
    `IPRPF_ASSERT_NEXT(a_result_follows_input, out_transfer && !in_valid_reg,
        !m_valid, "result appeared with no input in flight")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for ipv4_route_prefix_filter_top: route transfers in,
// accept flags out, minimum prefix thresholds set over apb
// depends on iprpf_pkg and the design sources only
`timescale 1ns / 100ps

module tb;
    import iprpf_pkg::*;

    // apb addresses of the two threshold registers
    localparam logic [PADDR_W-1:0] ADDR_MIN_PUBLIC = 'h0;
    localparam logic [PADDR_W-1:0] ADDR_MIN_LOCAL  = 'h4;

    // bogon ranges: any overlap with the route span rejects it
    localparam int BOGON_COUNT = 14;
    localparam logic [ADDR_W-1:0] BOGON_BASE [BOGON_COUNT] = '{
        32'h00000000, 32'h7f000000, 32'hc0000000, 32'hc0000200,
        32'hc01f0000, 32'hc01fc400, 32'hc034c100, 32'hc0586300,
        32'hc0af3000, 32'hc6120000, 32'hc6336400, 32'hcb007100,
        32'he0000000, 32'hf0000000
    };
    localparam int BOGON_LEN [BOGON_COUNT] = '{
        8, 8, 24, 24, 24, 24, 24, 24, 24, 15, 24, 24, 4, 4
    };

    // private and shared space, held to the local minimum
    localparam int LAN_COUNT = 4;
    localparam logic [ADDR_W-1:0] LAN_BASE [LAN_COUNT] = '{
        32'h0a000000, 32'h64400000, 32'hac100000, 32'hc0a80000
    };
    localparam int LAN_LEN [LAN_COUNT] = '{8, 10, 12, 16};

    // 169.254/16
    localparam logic [15:0] LINK_LOCAL_NET = 16'ha9fe;

    // one pending route and the flag it should produce
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [PFX_W-1:0]  len;
        logic              accept;
    } route_verdict_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ADDR_W-1:0]  s_route_address = '0;
    logic [PFX_W-1:0]   s_prefix_length = '0;
    logic               m_valid;
    logic               m_ready = 1'b1;
    logic               m_accept;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // mirror of the threshold registers, as the block should hold them
    logic [PFX_W-1:0]   min_public_q = MIN_PUBLIC_RESET;
    logic [PFX_W-1:0]   min_local_q  = MIN_LOCAL_RESET;

    route_verdict_t     verdict_q [$];
    route_verdict_t     verdict_head;

    int err_count      = 0;
    int routes_sent    = 0;
    int routes_checked = 0;
    int accept_count   = 0;
    int reg_writes     = 0;
    int settings_count = 0;
    int backpressure   = 0;

    // idling control shared by the sender and the receiver
    bit idle_on     = 1'b1;
    int hold_left   = 0;
    int rx_gap_left = 0;

    ipv4_route_prefix_filter_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_route_address (s_route_address),
        .s_prefix_length (s_prefix_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accept        (m_accept),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // leading-ones mask for a prefix length
    function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
        if (len <= 0) return '0;
        if (len >= 32) return '1;
        return 32'hffffffff << (32 - len);
    endfunction

    function automatic logic predict_accept(input logic [ADDR_W-1:0] addr,
                                            input logic [PFX_W-1:0] len);
        logic [ADDR_W-1:0] m, lo, hi, rm, rlo, rhi;
        logic              ok, in_lan;
        // zero length and lengths past 32 never pass
        if (len == 0 || len > MAX_PREFIX) return 1'b0;
        m  = prefix_mask(int'(len));
        ok = ((addr & m) == addr);              // host bits must be clear
        if (addr[31:16] == LINK_LOCAL_NET) ok = 1'b0;
        lo = addr & m;
        hi = lo | ~m;
        for (int i = 0; i < BOGON_COUNT; i++) begin
            rm  = prefix_mask(BOGON_LEN[i]);
            rlo = BOGON_BASE[i] & rm;
            rhi = rlo | ~rm;
            if (lo <= rhi && rlo <= hi) ok = 1'b0;
        end
        in_lan = 1'b0;
        for (int j = 0; j < LAN_COUNT; j++) begin
            rm = prefix_mask(LAN_LEN[j]);
            if ((addr & rm) == (LAN_BASE[j] & rm)) in_lan = 1'b1;
        end
        if (len < (in_lan ? min_local_q : min_public_q)) ok = 1'b0;
        return ok;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // every result transfer is matched against the oldest pending route
    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready) backpressure++;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result %0b with no route pending", m_accept));
            end else begin
                verdict_head = verdict_q.pop_front();
                routes_checked++;
                if (verdict_head.accept) accept_count++;
                if (m_accept !== verdict_head.accept)
                    report_mismatch($sformatf("route %h/%0d: accept %b, expected %b",
                        verdict_head.addr, verdict_head.len, m_accept,
                        verdict_head.accept));
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            // start a stall burst; rx_gap_left holds the rest of it
            rx_gap_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one route and hold it until the transfer; valid stays high after
    task automatic send_route(input logic [ADDR_W-1:0] addr, input logic [PFX_W-1:0] len);
        route_verdict_t v;
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_route_address <= addr;
        s_prefix_length <= len;
        do @(posedge aclk); while (!s_ready);
        v.addr   = addr;
        v.len    = len;
        v.accept = predict_accept(addr, len);
        verdict_q.push_back(v);
        routes_sent++;
    endtask

    // sender idles, holding valid low until the random count n runs out
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 7);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // drop valid, then wait for every pending result and the pipeline to settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly well-formed routes, a good share near the special ranges,
    // the rest noise and routes with stray host bits
    task automatic gen_route(output logic [ADDR_W-1:0] addr, output logic [PFX_W-1:0] len);
        int               kind, k;
        logic [ADDR_W-1:0] base;
        kind = $urandom_range(0, 99);
        len  = PFX_W'($urandom_range(1, 32));
        if (kind < 55) begin
            addr = $urandom & prefix_mask(int'(len));
        end else if (kind < 85) begin
            k = $urandom_range(0, BOGON_COUNT + LAN_COUNT);
            if (k < BOGON_COUNT) base = BOGON_BASE[k];
            else if (k < BOGON_COUNT + LAN_COUNT) base = LAN_BASE[k - BOGON_COUNT];
            else base = {LINK_LOCAL_NET, 16'h0000};
            addr = (base | ($urandom >> $urandom_range(4, 28))) & prefix_mask(int'(len));
        end else if (kind < 93) begin
            addr = $urandom;
            len  = PFX_W'($urandom_range(0, 63));
        end else begin
            addr = $urandom & prefix_mask(int'(len));
            if (len < 32) addr = addr | (32'h1 << $urandom_range(0, 31 - len));
        end
    endtask

    task automatic run_random(input int n);
        logic [ADDR_W-1:0] addr;
        logic [PFX_W-1:0]  len;
        for (int i = 0; i < n; i++) begin
            if (idle_on && $urandom_range(0, 5) == 0) sender_gap();
            gen_route(addr, len);
            send_route(addr, len);
        end
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write one threshold with junk in the unused upper bits, then read it back
    task automatic write_threshold(input logic [PADDR_W-1:0] addr, input logic [PFX_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        apb_write(addr, {$urandom} & ~32'h3f | val);
        if (addr == ADDR_MIN_PUBLIC) min_public_q = val;
        else min_local_q = val;
        apb_read(addr, rd);
        if (rd[PFX_W-1:0] !== val)
            report_mismatch($sformatf("register at %0h reads %0d, expected %0d",
                addr, rd[PFX_W-1:0], val));
    endtask

    task automatic set_thresholds(input logic [PFX_W-1:0] pub, input logic [PFX_W-1:0] loc);
        wait_idle();
        write_threshold(ADDR_MIN_PUBLIC, pub);
        write_threshold(ADDR_MIN_LOCAL, loc);
        settings_count++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero and oversized lengths, host bits, link-local, threshold edges,
    // run at the reset thresholds (public 16, local 24)
    task automatic test_edge_routes();
        send_route(32'h08080800, 6'd0);
        send_route(32'hffffffff, 6'd63);
        send_route(32'h08080800, 6'd33);
        send_route(32'h08080801, 6'd24);
        send_route(32'ha9fe0100, 6'd24);
        send_route(32'h08080808, 6'd32);
        send_route(32'h0b000000, 6'd16);
        send_route(32'h0b000000, 6'd15);
        send_route(32'h0a010200, 6'd24);
        send_route(32'hc0a80000, 6'd16);
        send_route(32'h64400000, 6'd23);
        send_route(32'hac100000, 6'd24);
    endtask

    // each bogon range itself, wide routes spanning one, and a neighbor
    task automatic test_bogon_ranges();
        for (int i = 0; i < BOGON_COUNT; i++)
            send_route(BOGON_BASE[i], PFX_W'(BOGON_LEN[i]));
        send_route(32'h80000000, 6'd1);
        send_route(32'hc6100000, 6'd14);
        send_route(32'hdfff0000, 6'd16);
    endtask

    // sweep threshold pairs, extremes and out-of-range values included;
    // every other phase runs without idling
    task automatic test_threshold_sweep();
        logic [PFX_W-1:0] pub_set [7] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd20, 6'd8, 6'd16};
        logic [PFX_W-1:0] loc_set [7] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd8, 6'd28, 6'd24};
        for (int p = 0; p < 7; p++) begin
            set_thresholds(pub_set[p], loc_set[p]);
            idle_on = (p % 2 == 0);
            run_random(200);
        end
        idle_on = 1'b1;
    endtask

    // result side holds off long enough for the pipeline to fill and push back
    task automatic test_backpressure();
        wait_idle();
        idle_on   = 1'b0;
        hold_left = 80;
        run_random(24);
        wait_idle();
    endtask

    // closing stretch with no idling on either side
    task automatic test_streaming();
        idle_on = 1'b0;
        set_thresholds(PFX_W'($urandom_range(1, 32)), PFX_W'($urandom_range(1, 32)));
        run_random(250);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        // synchronous reset, released at a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_routes();
        test_bogon_ranges();
        test_threshold_sweep();
        test_backpressure();
        test_streaming();

        // drain and let any stray result show up
        wait_idle();
        repeat (10) @(posedge aclk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

        $display("tb: %0d routes sent, %0d checked, %0d accepted, %0d rejected",
            routes_sent, routes_checked, accept_count, routes_checked - accept_count);
        $display("tb: %0d threshold settings via %0d register writes, %0d input stall cycles",
            settings_count, reg_writes, backpressure);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("tb: timeout with %0d results pending", verdict_q.size());
        $display("tb: done, errors");
        $finish;
    end

endmodule
